// ----- rtl/core/assert_macros.svh -----
// Assertion shorthands for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pac assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pac assertion failed");

`endif

// ----- rtl/core/pac_pkg.sv -----
package pac_pkg;

    localparam int WINDOW_LEN  = 3;
    localparam int SAMPLE_BITS = 12;

    localparam int AXIS_BITS = 8;
    localparam int Q_BITS    = 8;
    localparam int AXIS_SPAN = 254;
    localparam int AXIS_BIAS = 127;

    localparam int SLOT_BITS  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int MEAN_SHIFT = SUM_BITS + $clog2(WINDOW_LEN) + 1;
    localparam int RECIP_BITS = MEAN_SHIFT + 1;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam int NUM_BITS   = SAMPLE_BITS + Q_BITS;
    localparam int CNT_BITS   = $clog2(Q_BITS);

    localparam logic [RECIP_BITS-1:0] MEAN_RECIP =
        RECIP_BITS'((2 ** MEAN_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN);

    localparam logic [SAMPLE_BITS-1:0] ACCEL_LOW_RESET  = SAMPLE_BITS'(1108);
    localparam logic [SAMPLE_BITS-1:0] ACCEL_HIGH_RESET = SAMPLE_BITS'(1975);
    localparam logic [SAMPLE_BITS-1:0] BRAKE_LOW_RESET  = SAMPLE_BITS'(1127);
    localparam logic [SAMPLE_BITS-1:0] BRAKE_HIGH_RESET = SAMPLE_BITS'(1975);

    typedef enum logic [1:0] {
        CFG_ACCEL_LOW  = 2'd0,
        CFG_ACCEL_HIGH = 2'd1,
        CFG_BRAKE_LOW  = 2'd2,
        CFG_BRAKE_HIGH = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        L_IDLE,
        L_MEAN,
        L_CLAMP,
        L_DIV,
        L_DONE
    } lane_state_t;

    typedef enum logic {
        T_IDLE,
        T_BUSY
    } top_state_t;

    typedef struct packed {
        logic                 start;
        logic                 ack;
        logic [SLOT_BITS-1:0] slot;
    } lane_ctrl_t;

    typedef struct packed {
        logic                        done;
        logic signed [AXIS_BITS-1:0] axis;
    } lane_status_t;

endpackage

// ----- rtl/core/pac_ifs.sv -----
interface pac_pedal_if
    import pac_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] raw_accel;
    logic [SAMPLE_BITS-1:0] raw_brake;
    logic                   button_one_level;
    logic                   button_two_level;

    modport source (output valid, raw_accel, raw_brake, button_one_level,
                    button_two_level, input ready);
    modport sink (input valid, raw_accel, raw_brake, button_one_level,
                  button_two_level, output ready);
endinterface

interface pac_report_if
    import pac_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic signed [AXIS_BITS-1:0] accel_axis;
    logic signed [AXIS_BITS-1:0] brake_axis;
    logic                        button_one_pressed;
    logic                        button_two_pressed;
    logic                        triggers_changed;
    logic                        report_update;

    modport source (output valid, accel_axis, brake_axis, button_one_pressed,
                    button_two_pressed, triggers_changed, report_update,
                    input ready);
    modport sink (input valid, accel_axis, brake_axis, button_one_pressed,
                  button_two_pressed, triggers_changed, report_update,
                  output ready);
endinterface

interface pac_cfg_if
    import pac_pkg::*;
;
    logic                   valid;
    logic                   ready;
    cfg_idx_t               index;
    logic [SAMPLE_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/pac_lane.sv -----
module pac_lane
    import pac_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lane_ctrl_t             ctrl,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] lo,
    input  logic [SAMPLE_BITS-1:0] hi,
    output lane_status_t           status
);

    logic [SAMPLE_BITS-1:0] window_reg [WINDOW_LEN];
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    lane_state_t            state_reg;
    lane_state_t            state_next;

    logic [SAMPLE_BITS-1:0] mean_reg;
    logic                   eq_reg;
    logic [NUM_BITS-1:0]    rem_reg;
    logic [NUM_BITS-1:0]    den_sh_reg;
    logic [Q_BITS-1:0]      quo_reg;
    logic [CNT_BITS-1:0]    cnt_reg;

    logic [PROD_BITS-1:0]   mean_prod;
    logic                   swap;
    logic [SAMPLE_BITS-1:0] bmin;
    logic [SAMPLE_BITS-1:0] bmax;
    logic [SAMPLE_BITS-1:0] x_clamped;
    logic [SAMPLE_BITS-1:0] num_mag;
    logic [SAMPLE_BITS-1:0] den_mag;
    logic [NUM_BITS-1:0]    num_scaled;
    logic                   rem_ge;
    logic [AXIS_BITS:0]     axis_wide;

    // The running sum replaces the outgoing ring entry with the new sample.
    assign sum_next = sum_reg - SUM_BITS'(window_reg[ctrl.slot]) + SUM_BITS'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
            sum_reg   <= '0;
            state_reg <= L_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.start)
            begin
                window_reg[ctrl.slot] <= sample;
                sum_reg               <= sum_next;
            end
        end
    end

    assign mean_prod  = PROD_BITS'(sum_reg) * PROD_BITS'(MEAN_RECIP);
    assign swap       = lo > hi;
    assign bmin       = swap ? hi : lo;
    assign bmax       = swap ? lo : hi;
    assign num_mag    = swap ? (lo - x_clamped) : (x_clamped - lo);
    assign den_mag    = swap ? (lo - hi) : (hi - lo);
    assign num_scaled = NUM_BITS'(num_mag) * NUM_BITS'(AXIS_SPAN);
    assign rem_ge     = rem_reg >= den_sh_reg;

    always_comb
    begin
        priority if (mean_reg < bmin)
        begin
            x_clamped = bmin;
        end
        else if (mean_reg > bmax)
        begin
            x_clamped = bmax;
        end
        else
        begin
            x_clamped = mean_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = L_MEAN;
                end
            end
            L_MEAN:
            begin
                state_next = L_CLAMP;
            end
            L_CLAMP:
            begin
                state_next = L_DIV;
            end
            L_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = L_DONE;
                end
            end
            L_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    // The quotient never exceeds the span, so one bit per step over Q_BITS steps suffices.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            L_MEAN:
            begin
                mean_reg <= mean_prod[MEAN_SHIFT +: SAMPLE_BITS];
            end
            L_CLAMP:
            begin
                eq_reg     <= lo == hi;
                rem_reg    <= num_scaled;
                den_sh_reg <= NUM_BITS'(den_mag) << (Q_BITS - 1);
                cnt_reg    <= CNT_BITS'(Q_BITS - 1);
            end
            L_DIV:
            begin
                if (rem_ge)
                begin
                    rem_reg <= rem_reg - den_sh_reg;
                end
                quo_reg    <= {quo_reg[Q_BITS-2:0], rem_ge};
                den_sh_reg <= den_sh_reg >> 1;
                cnt_reg    <= cnt_reg - CNT_BITS'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign axis_wide = {1'b0, quo_reg} - (AXIS_BITS + 1)'(AXIS_BIAS);

    assign status.done = state_reg == L_DONE;
    assign status.axis = eq_reg ? -AXIS_BITS'(AXIS_BIAS) : signed'(axis_wide[AXIS_BITS-1:0]);

endmodule

// ----- rtl/core/pedal_axis_conditioner.sv -----
// Each pedal lane holds an 8-step shift-subtract divider; a new request is taken only
// after both lanes' results have moved to the report register, and may be taken while
// that report still waits.
// Reset (rst_n, asynchronous, active low) clears both averaging rings, the ring slot,
// the last reported axes and buttons, and loads the default pedal bounds.
`include "assert_macros.svh"

module pedal_axis_conditioner
    import pac_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    pac_pedal_if.sink     pedals,
    pac_report_if.source  report,
    pac_cfg_if.sink       cfg
);

    logic [SAMPLE_BITS-1:0] accel_low_reg;
    logic [SAMPLE_BITS-1:0] accel_high_reg;
    logic [SAMPLE_BITS-1:0] brake_low_reg;
    logic [SAMPLE_BITS-1:0] brake_high_reg;

    top_state_t             state_reg;
    top_state_t             state_next;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [SLOT_BITS-1:0]   slot_next;
    logic                   btn_one_reg;
    logic                   btn_two_reg;

    logic signed [AXIS_BITS-1:0] last_accel_reg;
    logic signed [AXIS_BITS-1:0] last_brake_reg;
    logic                        last_one_reg;
    logic                        last_two_reg;

    logic                        out_valid_reg;
    logic signed [AXIS_BITS-1:0] out_accel_reg;
    logic signed [AXIS_BITS-1:0] out_brake_reg;
    logic                        out_one_reg;
    logic                        out_two_reg;
    logic                        out_trig_reg;
    logic                        out_update_reg;

    logic          accept;
    logic          merge;
    logic          trig;
    logic          btn_change;
    lane_ctrl_t    lane_ctrl;
    lane_status_t  accel_status;
    lane_status_t  brake_status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_low_reg  <= ACCEL_LOW_RESET;
            accel_high_reg <= ACCEL_HIGH_RESET;
            brake_low_reg  <= BRAKE_LOW_RESET;
            brake_high_reg <= BRAKE_HIGH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ACCEL_LOW:  accel_low_reg  <= cfg.data;
                CFG_ACCEL_HIGH: accel_high_reg <= cfg.data;
                CFG_BRAKE_LOW:  brake_low_reg  <= cfg.data;
                CFG_BRAKE_HIGH: brake_high_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    assign pedals.ready = state_reg == T_IDLE;
    assign accept       = pedals.valid && pedals.ready;
    assign slot_next    = (slot_reg == SLOT_BITS'(WINDOW_LEN - 1)) ? '0 : slot_reg + SLOT_BITS'(1);

    assign lane_ctrl.start = accept;
    assign lane_ctrl.ack   = merge;
    assign lane_ctrl.slot  = slot_reg;

    pac_lane u_accel_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .sample (pedals.raw_accel),
        .lo     (accel_low_reg),
        .hi     (accel_high_reg),
        .status (accel_status)
    );

    pac_lane u_brake_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .sample (pedals.raw_brake),
        .lo     (brake_low_reg),
        .hi     (brake_high_reg),
        .status (brake_status)
    );

    always_comb
    begin
        state_next = state_reg;
        merge      = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = T_BUSY;
                end
            end
            T_BUSY:
            begin
                if (accel_status.done && brake_status.done && (!out_valid_reg || report.ready))
                begin
                    merge      = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign trig       = (accel_status.axis != last_accel_reg) ||
                        (brake_status.axis != last_brake_reg);
    assign btn_change = (btn_one_reg != last_one_reg) || (btn_two_reg != last_two_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            slot_reg       <= '0;
            last_accel_reg <= '0;
            last_brake_reg <= '0;
            last_one_reg   <= 1'b0;
            last_two_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                slot_reg <= slot_next;
            end
            if (merge)
            begin
                last_one_reg  <= btn_one_reg;
                last_two_reg  <= btn_two_reg;
                out_valid_reg <= 1'b1;
                if (trig)
                begin
                    last_accel_reg <= accel_status.axis;
                    last_brake_reg <= brake_status.axis;
                end
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            btn_one_reg <= !pedals.button_one_level;
            btn_two_reg <= !pedals.button_two_level;
        end
        if (merge)
        begin
            out_accel_reg  <= accel_status.axis;
            out_brake_reg  <= brake_status.axis;
            out_one_reg    <= btn_one_reg;
            out_two_reg    <= btn_two_reg;
            out_trig_reg   <= trig;
            out_update_reg <= trig || btn_change;
        end
    end

    assign report.valid              = out_valid_reg;
    assign report.accel_axis         = out_accel_reg;
    assign report.brake_axis         = out_brake_reg;
    assign report.button_one_pressed = out_one_reg;
    assign report.button_two_pressed = out_two_reg;
    assign report.triggers_changed   = out_trig_reg;
    assign report.report_update      = out_update_reg;

    `PAC_ASSERT_NOW(a_lanes_in_step, clk, rst_n, 1'b1, accel_status.done == brake_status.done)
    `PAC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !pedals.ready)
    `PAC_ASSERT_NOW(a_trig_flags_update, clk, rst_n, out_valid_reg,
        !out_trig_reg || out_update_reg)
    `PAC_ASSERT_NOW(a_axis_in_range, clk, rst_n, merge,
        accel_status.axis != -AXIS_BITS'(128) && brake_status.axis != -AXIS_BITS'(128))

endmodule

// ----- tb/pedal_report_checker.sv -----
module pedal_report_checker
    import pac_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    pac_pedal_if  pedals,
    pac_report_if report,
    pac_cfg_if    cfg,
    output int    errors,
    output int    pending
);

    typedef struct {
        logic signed [AXIS_BITS-1:0] accel_axis;
        logic signed [AXIS_BITS-1:0] brake_axis;
        logic                        button_one_pressed;
        logic                        button_two_pressed;
        logic                        triggers_changed;
        logic                        report_update;
    } pedal_report_t;

    logic [SAMPLE_BITS-1:0]      bound [4];
    logic [SAMPLE_BITS-1:0]      accel_ring [WINDOW_LEN];
    logic [SAMPLE_BITS-1:0]      brake_ring [WINDOW_LEN];
    int unsigned                 ring_slot;
    logic signed [AXIS_BITS-1:0] last_accel_axis;
    logic signed [AXIS_BITS-1:0] last_brake_axis;
    logic                        last_one_pressed;
    logic                        last_two_pressed;
    pedal_report_t               expected_reports [$];
    int                          mismatches;

    function automatic int scale_to_axis(input int mean, input int lo, input int hi);
        int x;
        int q;
        if (lo == hi)
            return -AXIS_BIAS;
        x = mean;
        if (lo < hi)
        begin
            if (x < lo)
                x = lo;
            if (x > hi)
                x = hi;
            q = (x - lo) * AXIS_SPAN / (hi - lo);
        end
        else
        begin
            if (x < hi)
                x = hi;
            if (x > lo)
                x = lo;
            q = (lo - x) * AXIS_SPAN / (lo - hi);
        end
        q = q - AXIS_BIAS;
        if (q > AXIS_BIAS)
            q = AXIS_BIAS;
        if (q < -AXIS_BIAS)
            q = -AXIS_BIAS;
        return q;
    endfunction

    function automatic pedal_report_t predict_report(
        input logic [SAMPLE_BITS-1:0] accel,
        input logic [SAMPLE_BITS-1:0] brake,
        input logic                   level_one,
        input logic                   level_two
    );
        pedal_report_t r;
        int            accel_sum;
        int            brake_sum;
        accel_ring[ring_slot] = accel;
        brake_ring[ring_slot] = brake;
        ring_slot = (ring_slot + 1) % WINDOW_LEN;
        accel_sum = 0;
        brake_sum = 0;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            accel_sum += int'(accel_ring[i]);
            brake_sum += int'(brake_ring[i]);
        end
        r.accel_axis = AXIS_BITS'(scale_to_axis(accel_sum / WINDOW_LEN,
            int'(bound[CFG_ACCEL_LOW]), int'(bound[CFG_ACCEL_HIGH])));
        r.brake_axis = AXIS_BITS'(scale_to_axis(brake_sum / WINDOW_LEN,
            int'(bound[CFG_BRAKE_LOW]), int'(bound[CFG_BRAKE_HIGH])));
        r.button_one_pressed = ~level_one;
        r.button_two_pressed = ~level_two;
        r.triggers_changed = (r.accel_axis != last_accel_axis)
                          || (r.brake_axis != last_brake_axis);
        r.report_update = r.triggers_changed
                       || (r.button_one_pressed != last_one_pressed)
                       || (r.button_two_pressed != last_two_pressed);
        last_accel_axis  = r.accel_axis;
        last_brake_axis  = r.brake_axis;
        last_one_pressed = r.button_one_pressed;
        last_two_pressed = r.button_two_pressed;
        return r;
    endfunction

    function automatic void check_field(
        input string              field,
        input logic signed [31:0] want,
        input logic signed [31:0] got
    );
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pedal_report_t want;
        if (!rst_n)
        begin
            bound[CFG_ACCEL_LOW]  = ACCEL_LOW_RESET;
            bound[CFG_ACCEL_HIGH] = ACCEL_HIGH_RESET;
            bound[CFG_BRAKE_LOW]  = BRAKE_LOW_RESET;
            bound[CFG_BRAKE_HIGH] = BRAKE_HIGH_RESET;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                accel_ring[i] = '0;
                brake_ring[i] = '0;
            end
            ring_slot        = 0;
            last_accel_axis  = '0;
            last_brake_axis  = '0;
            last_one_pressed = 1'b0;
            last_two_pressed = 1'b0;
            expected_reports.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                bound[cfg.index] = cfg.data;
            if (report.valid && report.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report accepted with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("accel_axis", want.accel_axis, report.accel_axis);
                    check_field("brake_axis", want.brake_axis, report.brake_axis);
                    check_field("button_one_pressed", want.button_one_pressed,
                                report.button_one_pressed);
                    check_field("button_two_pressed", want.button_two_pressed,
                                report.button_two_pressed);
                    check_field("triggers_changed", want.triggers_changed,
                                report.triggers_changed);
                    check_field("report_update", want.report_update,
                                report.report_update);
                end
            end
            if (pedals.valid && pedals.ready)
                expected_reports.push_back(predict_report(pedals.raw_accel, pedals.raw_brake,
                    pedals.button_one_level, pedals.button_two_level));
            errors  <= mismatches;
            pending <= expected_reports.size();
        end
    end

endmodule

// ----- tb/tb_pedal_axis_conditioner.sv -----
module tb_pedal_axis_conditioner;
    import pac_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int LIMIT           = 400000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int LONG_STALL      = 300;
    localparam int TAIL_CYCLES     = 24;
    localparam int RAW_MAX         = (1 << SAMPLE_BITS) - 1;

    localparam logic [SAMPLE_BITS-1:0] RAW_FULL = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    int   errors;
    int   pending;
    int   sender_odds = 25;
    int   sink_odds   = 8;
    logic long_stall_go = 1'b0;

    logic [SAMPLE_BITS-1:0] cur_bound [4];
    logic [SAMPLE_BITS-1:0] last_accel_raw;
    logic [SAMPLE_BITS-1:0] last_brake_raw;
    logic                   last_level_one;
    logic                   last_level_two;

    pac_pedal_if  pedals();
    pac_report_if report();
    pac_cfg_if    cfg();

    pedal_axis_conditioner u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pedals (pedals),
        .report (report),
        .cfg    (cfg)
    );

    pedal_report_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .pedals  (pedals),
        .report  (report),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : report_sink
        bit long_stall_done;
        long_stall_done = 1'b0;
        report.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_stall_go && !long_stall_done)
            begin
                report.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                long_stall_done = 1'b1;
                report.ready <= 1'b1;
            end
            else if ($urandom_range(99) < sink_odds)
            begin
                report.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                report.ready <= 1'b1;
            end
            else
                report.ready <= 1'b1;
        end
    end

    task automatic send_sample(
        input logic [SAMPLE_BITS-1:0] accel,
        input logic [SAMPLE_BITS-1:0] brake,
        input logic                   level_one,
        input logic                   level_two
    );
        pedals.valid            <= 1'b1;
        pedals.raw_accel        <= accel;
        pedals.raw_brake        <= brake;
        pedals.button_one_level <= level_one;
        pedals.button_two_level <= level_two;
        @(posedge clk);
        while (!pedals.ready)
            @(posedge clk);
        last_accel_raw = accel;
        last_brake_raw = brake;
        last_level_one = level_one;
        last_level_two = level_two;
        if ($urandom_range(99) < sender_odds)
        begin
            pedals.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain_reports();
        pedals.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_bounds(
        input logic [SAMPLE_BITS-1:0] accel_lo,
        input logic [SAMPLE_BITS-1:0] accel_hi,
        input logic [SAMPLE_BITS-1:0] brake_lo,
        input logic [SAMPLE_BITS-1:0] brake_hi
    );
        logic [SAMPLE_BITS-1:0] vals [4];
        vals = '{accel_lo, accel_hi, brake_lo, brake_hi};
        for (int i = 0; i < 4; i++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= cfg_idx_t'(i);
            cfg.data  <= vals[i];
            @(posedge clk);
            while (!cfg.ready)
                @(posedge clk);
            cur_bound[i] = vals[i];
        end
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_raw(
        input logic [SAMPLE_BITS-1:0] prev,
        input logic [SAMPLE_BITS-1:0] lo,
        input logic [SAMPLE_BITS-1:0] hi
    );
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4:
                return SAMPLE_BITS'($urandom);
            5, 6:
                return prev;
            default:
            begin
                v = ($urandom_range(1) == 1) ? int'(lo) : int'(hi);
                v = v + int'($urandom_range(8)) - 4;
                if (v < 0)
                    v = 0;
                if (v > RAW_MAX)
                    v = RAW_MAX;
                return SAMPLE_BITS'(v);
            end
        endcase
    endfunction

    task automatic send_random();
        logic [SAMPLE_BITS-1:0] accel;
        logic [SAMPLE_BITS-1:0] brake;
        logic                   level_one;
        logic                   level_two;
        if ($urandom_range(99) < 35)
        begin
            accel = last_accel_raw;
            brake = last_brake_raw;
            level_one = last_level_one;
            level_two = last_level_two;
        end
        else
        begin
            accel = pick_raw(last_accel_raw, cur_bound[CFG_ACCEL_LOW],
                             cur_bound[CFG_ACCEL_HIGH]);
            brake = pick_raw(last_brake_raw, cur_bound[CFG_BRAKE_LOW],
                             cur_bound[CFG_BRAKE_HIGH]);
            level_one = ($urandom_range(99) < 20) ? ~last_level_one : last_level_one;
            level_two = ($urandom_range(99) < 20) ? ~last_level_two : last_level_two;
        end
        send_sample(accel, brake, level_one, level_two);
    endtask

    initial
    begin : stimulus
        logic [SAMPLE_BITS-1:0] shared;
        pedals.valid            = 1'b0;
        pedals.raw_accel        = '0;
        pedals.raw_brake        = '0;
        pedals.button_one_level = 1'b1;
        pedals.button_two_level = 1'b1;
        cfg.valid = 1'b0;
        cfg.index = CFG_ACCEL_LOW;
        cfg.data  = '0;
        cur_bound[CFG_ACCEL_LOW]  = ACCEL_LOW_RESET;
        cur_bound[CFG_ACCEL_HIGH] = ACCEL_HIGH_RESET;
        cur_bound[CFG_BRAKE_LOW]  = BRAKE_LOW_RESET;
        cur_bound[CFG_BRAKE_HIGH] = BRAKE_HIGH_RESET;
        last_accel_raw = '0;
        last_brake_raw = '0;
        last_level_one = 1'b1;
        last_level_two = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first averages still hold the zeros the rings start with.
        send_sample('0, '0, 1'b1, 1'b1);
        send_sample('0, '0, 1'b1, 1'b1);
        repeat (3) send_sample(RAW_FULL, RAW_FULL, 1'b0, 1'b0);
        send_sample(RAW_FULL, RAW_FULL, 1'b1, 1'b0);
        send_sample('0, RAW_FULL, 1'b0, 1'b1);
        send_sample(RAW_FULL, '0, 1'b1, 1'b1);
        repeat (3) send_sample(ACCEL_LOW_RESET, BRAKE_LOW_RESET, 1'b1, 1'b1);
        repeat (3) send_sample(ACCEL_HIGH_RESET, BRAKE_HIGH_RESET, 1'b1, 1'b1);
        repeat (2) send_sample(12'd2048, 12'd2048, 1'b0, 1'b0);
        send_sample(12'd1500, 12'd1600, 1'b1, 1'b0);
        send_sample(12'd1200, 12'd1300, 1'b0, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_reports();
            case (p)
                1:
                    set_bounds('0, RAW_FULL, '0, RAW_FULL);
                2:
                begin
                    set_bounds(RAW_FULL, '0, 12'd3000, 12'd100);
                    sender_odds <= 40;
                    sink_odds   <= 15;
                end
                3:
                begin
                    set_bounds(12'd2000, 12'd2000, '0, '0);
                    sender_odds <= 0;
                    sink_odds   <= 0;
                end
                4:
                begin
                    set_bounds(RAW_FULL, RAW_FULL, 12'd1, 12'd2);
                    sender_odds <= 25;
                    sink_odds   <= 8;
                end
                5:
                begin
                    set_bounds(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                               SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
                    sender_odds <= 10;
                    sink_odds   <= 3;
                end
                6:
                begin
                    shared = SAMPLE_BITS'($urandom);
                    set_bounds(shared, ($urandom_range(1) == 1) ? shared : SAMPLE_BITS'($urandom),
                               SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
                    sender_odds <= 25;
                    sink_odds   <= 8;
                end
                7:
                begin
                    set_bounds(ACCEL_LOW_RESET, ACCEL_HIGH_RESET,
                               BRAKE_LOW_RESET, BRAKE_HIGH_RESET);
                    sender_odds <= 0;
                    sink_odds   <= 0;
                end
                default:
                    ;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 1 && n == 20)
                    long_stall_go <= 1'b1;
                if (p == 2 && n == ITEMS_PER_PHASE / 2)
                    drain_reports();
                send_random();
            end
        end

        drain_reports();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
